### rtl/ssvf_pkg.sv
`timescale 1ns / 1ps

package ssvf_pkg;

	// integrator store: two integrators per channel per stage
	localparam int INTEG_WIDTH      = 32;
	localparam int INTEG_COUNT      = 8;
	localparam int INTEG_ADDR_WIDTH = 3;

	// multiplier data operand: holds ic1, v3 and v1 without overflow
	localparam int DATA_WIDTH = 36;

	// configuration register indexes
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A1     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A2     = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A3     = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DAMPING     = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILTER_MODE = 3'd4;

	// filter modes; unused codes behave as notch
	localparam int MODE_WIDTH = 3;
	localparam logic [MODE_WIDTH-1:0] MODE_LP12     = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_LP24     = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_BANDPASS = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_HIGHPASS = 3'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_NOTCH    = 3'd4;

	// sequencer states, one filter step runs RD1 through Y
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_V1,
		ST_M4,
		ST_M5,
		ST_V2,
		ST_WR2,
		ST_Y,
		ST_DONE
	} state_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic acc_init;
		logic acc_add;
	} mac_ctrl_t;

endpackage

### rtl/ssvf_ram.sv
`timescale 1ns / 1ps

module ssvf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/ssvf_mac.sv
`timescale 1ns / 1ps

module ssvf_mac #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                                    clk,
	input  ssvf_pkg::mac_ctrl_t                                     ctrl,
	input  logic        [COEF_FRAC_BITS+1:0]                        coef,
	input  logic signed [ssvf_pkg::DATA_WIDTH-1:0]                  data,
	output logic signed [ssvf_pkg::DATA_WIDTH+COEF_FRAC_BITS+3:0]   acc
);

	import ssvf_pkg::*;

	localparam int PW = DATA_WIDTH + COEF_FRAC_BITS + 3;
	localparam int AW = PW + 1;
	localparam logic signed [AW-1:0] ROUND_HALF =
		{{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] prod_ext;

	assign prod_ext = AW'(prod_q);

	// product register, then accumulate; init adds the rounding half
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= $signed({1'b0, coef}) * data;
		end
		if (ctrl.acc_init) begin
			acc_q <= ROUND_HALF + prod_ext;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/stereo_state_variable_filter.sv
`timescale 1ns / 1ps

// Stereo trapezoidal state variable filter on one shared multiply-accumulate unit.
// Each filter step runs states RD1 through Y (5 products through the one multiplier plus
// integrator reads and writes); an item runs 2 steps, 4 in 24 dB low-pass mode.
// A new item is taken only after the last result is loaded into the output register.
// arst_n clears the sequencer, loads register defaults and marks all integrators as zero.

module stereo_state_variable_filter #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	// input items
	input  logic                                             s_axis_tvalid,
	output logic                                             s_axis_tready,
	// sample_left, sample_right, zero fill
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]              s_axis_tdata,
	// result items
	output logic                                             m_axis_tvalid,
	input  logic                                             m_axis_tready,
	// filtered_left, filtered_right, zero fill
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]              m_axis_tdata,
	// configuration writes
	input  logic                                             cfg_valid,
	output logic                                             cfg_ready,
	input  logic [ssvf_pkg::CFG_INDEX_WIDTH-1:0]             cfg_index,
	input  logic [COEF_FRAC_BITS+1:0]                        cfg_data
);

	import ssvf_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int F   = COEF_FRAC_BITS;
	localparam int CW  = F + 1;
	localparam int KW  = F + 2;
	localparam int TW  = ((2*SAMPLE_WIDTH+7)/8)*8;
	localparam int DW  = DATA_WIDTH;
	localparam int IW  = INTEG_WIDTH;
	localparam int AW  = DW + F + 4;
	localparam int YW  = DW + 3;
	localparam int TDW = DW + 2;

	// configuration
	logic [CW-1:0]         coef_a1_q, coef_a2_q, coef_a3_q;
	logic [KW-1:0]         damping_q;
	logic [MODE_WIDTH-1:0] mode_q;

	// sequencer and datapath
	state_t state_q, state_d;
	logic   ch_q, stage_q;
	logic signed [SW-1:0] x_q, xr_q, yl_q, yr_q;
	logic signed [SW-1:0] out_left_q, out_right_q;
	logic                 out_valid_q, out_load;
	logic signed [IW-1:0] ic1_q, ic2_q;
	logic signed [DW-1:0] v3_q, v1_q, v2_q;

	// integrator store
	logic [INTEG_COUNT-1:0]      integ_valid_q;
	logic                        rd_valid_q;
	logic                        ram_we;
	logic [INTEG_ADDR_WIDTH-1:0] ram_waddr, ram_raddr;
	logic [IW-1:0]               ram_wdata, ram_rdata;
	logic signed [IW-1:0]        rd_ic;

	// shared unit
	mac_ctrl_t            mac_ctrl;
	logic [KW-1:0]        mac_coef;
	logic signed [DW-1:0] mac_data;
	logic signed [AW-1:0] mac_acc;

	// arithmetic
	logic signed [DW-1:0]  acc_rnd;
	logic signed [YW-1:0]  kv1;
	logic signed [YW-1:0]  y_wide;
	logic signed [SW-1:0]  y_sat;
	logic                  y_ovf;
	logic signed [TDW-1:0] twice_diff;
	logic signed [IW-1:0]  integ_sat;
	logic                  integ_ovf;
	logic signed [DW-1:0]  v_sel;
	logic signed [IW-1:0]  ic_sel;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a1_q <= CW'(1) << F;
			coef_a2_q <= '0;
			coef_a3_q <= '0;
			damping_q <= KW'(2) << F;
			mode_q    <= MODE_LP12;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_A1:     coef_a1_q <= cfg_data[CW-1:0];
				REG_COEF_A2:     coef_a2_q <= cfg_data[CW-1:0];
				REG_COEF_A3:     coef_a3_q <= cfg_data[CW-1:0];
				REG_DAMPING:     damping_q <= cfg_data;
				REG_FILTER_MODE: mode_q    <= cfg_data[MODE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mac_ctrl      = '0;
		mac_coef      = '0;
		mac_data      = DW'(ic1_q);
		ram_we        = 1'b0;
		ram_raddr     = {stage_q, ch_q, 1'b0};
		ram_waddr     = {stage_q, ch_q, 1'b0};
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_RD1;
				end
			end
			ST_RD1: state_d = ST_RD2;
			ST_RD2: begin
				ram_raddr = {stage_q, ch_q, 1'b1};
				state_d   = ST_M1;
			end
			ST_M1: begin
				mac_ctrl.mul_en = 1'b1;
				mac_coef        = KW'(coef_a1_q);
				mac_data        = DW'(ic1_q);
				state_d         = ST_M2;
			end
			ST_M2: begin
				mac_ctrl.mul_en   = 1'b1;
				mac_ctrl.acc_init = 1'b1;
				mac_coef          = KW'(coef_a2_q);
				mac_data          = v3_q;
				state_d           = ST_M3;
			end
			ST_M3: begin
				mac_ctrl.acc_add = 1'b1;
				state_d          = ST_V1;
			end
			ST_V1: begin
				mac_ctrl.mul_en = 1'b1;
				mac_coef        = KW'(coef_a2_q);
				mac_data        = DW'(ic1_q);
				state_d         = ST_M4;
			end
			ST_M4: begin
				mac_ctrl.mul_en   = 1'b1;
				mac_ctrl.acc_init = 1'b1;
				mac_coef          = KW'(coef_a3_q);
				mac_data          = v3_q;
				state_d           = ST_M5;
			end
			ST_M5: begin
				mac_ctrl.acc_add = 1'b1;
				state_d          = ST_V2;
			end
			ST_V2: begin
				mac_ctrl.mul_en = 1'b1;
				mac_coef        = damping_q;
				mac_data        = v1_q;
				ram_we          = 1'b1;
				state_d         = ST_WR2;
			end
			ST_WR2: begin
				mac_ctrl.acc_init = 1'b1;
				ram_we            = 1'b1;
				ram_waddr         = {stage_q, ch_q, 1'b1};
				state_d           = ST_Y;
			end
			ST_Y: begin
				if ((mode_q == MODE_LP24 && !stage_q) || !ch_q) begin
					state_d = ST_RD1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// integrator store; entries never written read as zero
	ssvf_ram #(
		.WIDTH(IW),
		.DEPTH(INTEG_COUNT)
	) u_integ (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_valid_q <= '0;
			rd_valid_q    <= 1'b0;
		end else begin
			rd_valid_q <= integ_valid_q[ram_raddr];
			if (ram_we) begin
				integ_valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	assign rd_ic = rd_valid_q ? $signed(ram_rdata) : '0;

	// shared multiply-accumulate
	ssvf_mac #(
		.COEF_FRAC_BITS(F)
	) u_mac (
		.clk (clk),
		.ctrl(mac_ctrl),
		.coef(mac_coef),
		.data(mac_data),
		.acc (mac_acc)
	);

	// rounded accumulator value in sample LSBs
	assign acc_rnd = mac_acc[F+DW-1:F];
	assign kv1     = mac_acc[F+YW-1:F];

	// integrator update 2v - ic, saturated to the integrator width
	assign v_sel      = (state_q == ST_WR2) ? v2_q : v1_q;
	assign ic_sel     = (state_q == ST_WR2) ? ic2_q : ic1_q;
	assign twice_diff = {v_sel[DW-1], v_sel, 1'b0} - TDW'(ic_sel);
	assign integ_ovf  = !((&twice_diff[TDW-1:IW-1]) || !(|twice_diff[TDW-1:IW-1]));

	always_comb begin
		if (integ_ovf) begin
			integ_sat = twice_diff[TDW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end else begin
			integ_sat = twice_diff[IW-1:0];
		end
	end

	assign ram_wdata = integ_sat;

	// output tap by mode; second stage always takes v2
	always_comb begin
		if (stage_q) begin
			y_wide = YW'(v2_q);
		end else begin
			case (mode_q) inside
				MODE_LP12, MODE_LP24: y_wide = YW'(v2_q);
				MODE_BANDPASS:        y_wide = kv1;
				MODE_HIGHPASS:        y_wide = YW'(x_q) - kv1 - YW'(v2_q);
				default:              y_wide = YW'(x_q) - kv1;
			endcase
		end
	end

	assign y_ovf = !((&y_wide[YW-1:SW-1]) || !(|y_wide[YW-1:SW-1]));

	always_comb begin
		if (y_ovf) begin
			y_sat = y_wide[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			y_sat = y_wide[SW-1:0];
		end
	end

	// channel and stage tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= 1'b0;
			stage_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			ch_q    <= 1'b0;
			stage_q <= 1'b0;
		end else if (state_q == ST_Y) begin
			if (mode_q == MODE_LP24 && !stage_q) begin
				stage_q <= 1'b1;
			end else begin
				ch_q    <= 1'b1;
				stage_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					x_q  <= s_axis_tdata[SW-1:0];
					xr_q <= s_axis_tdata[2*SW-1:SW];
				end
			end
			ST_RD2: ic1_q <= rd_ic;
			ST_M1: begin
				ic2_q <= rd_ic;
				v3_q  <= DW'(x_q) - DW'(rd_ic);
			end
			ST_V1: v1_q <= acc_rnd;
			ST_V2: v2_q <= DW'(ic2_q) + acc_rnd;
			ST_Y: begin
				if (mode_q == MODE_LP24 && !stage_q) begin
					x_q <= y_sat;
				end else if (!ch_q) begin
					yl_q <= y_sat;
					x_q  <= xr_q;
				end else begin
					yr_q <= y_sat;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= yl_q;
			out_right_q <= yr_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TW'({out_right_q, out_left_q});

endmodule

### tb/stereo_svf_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and register channels, predicts every filtered
// stereo pair from its own copy of the registers and integrators, and compares.
module stereo_svf_checker #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [ssvf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COEF_FRAC_BITS+1:0]           cfg_data,
	output int                                  errors,
	output int                                  pending
);

	import ssvf_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = COEF_FRAC_BITS;

	typedef struct packed {
		logic [SW-1:0] left;
		logic [SW-1:0] right;
	} stereo_pair_t;

	// predictor copy of the registers and integrator store
	longint                coef_a1, coef_a2, coef_a3, damping;
	logic [MODE_WIDTH-1:0] filter_mode;
	longint                integ [INTEG_COUNT];

	stereo_pair_t expected_pairs [$];
	int           mismatches = 0;
	int           results_seen = 0;

	assign errors  = mismatches;
	assign pending = expected_pairs.size();

	function automatic void clear_state();
		coef_a1     = longint'(1) << F;
		coef_a2     = 0;
		coef_a3     = 0;
		damping     = longint'(2) << F;
		filter_mode = MODE_LP12;
		foreach (integ[i])
			integ[i] = 0;
		expected_pairs.delete();
	endfunction

	initial clear_state();

	// product sum back to sample LSB, round half up
	function automatic longint round_coef(input longint acc);
		return (acc + (longint'(1) << (F - 1))) >>> F;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// one trapezoidal step on the integrator pair at base
	function automatic void svf_step(input longint x, input int base,
			output longint v1, output longint v2);
		longint ic1, ic2, v3;
		ic1 = integ[base];
		ic2 = integ[base + 1];
		v3  = x - ic2;
		v1  = round_coef(coef_a1 * ic1 + coef_a2 * v3);
		v2  = ic2 + round_coef(coef_a2 * ic1 + coef_a3 * v3);
		integ[base]     = clamp(2 * v1 - ic1, INTEG_WIDTH);
		integ[base + 1] = clamp(2 * v2 - ic2, INTEG_WIDTH);
	endfunction

	// filtered sample of one channel; the second stage only runs in LP24
	function automatic logic [SW-1:0] filter_channel(input longint x, input int ch);
		longint v1, v2, kv1, y;
		svf_step(x, 2 * ch, v1, v2);
		kv1 = round_coef(damping * v1);
		case (filter_mode)
			MODE_LP12, MODE_LP24: y = v2;
			MODE_BANDPASS:        y = kv1;
			MODE_HIGHPASS:        y = x - kv1 - v2;
			default:              y = x - kv1;
		endcase
		y = clamp(y, SW);
		if (filter_mode == MODE_LP24) begin
			svf_step(y, 4 + 2 * ch, v1, v2);
			y = clamp(v2, SW);
		end
		return y[SW-1:0];
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("[%0t] %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		stereo_pair_t want;
		logic [SW-1:0] got_l, got_r, exp_l, exp_r;
		longint        xl, xr;
		if (!arst_n) begin
			clear_state();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COEF_A1:     coef_a1 = longint'(cfg_data[F:0]);
					REG_COEF_A2:     coef_a2 = longint'(cfg_data[F:0]);
					REG_COEF_A3:     coef_a3 = longint'(cfg_data[F:0]);
					REG_DAMPING:     damping = longint'(cfg_data[F+1:0]);
					REG_FILTER_MODE: filter_mode = cfg_data[MODE_WIDTH-1:0];
					default: ;
				endcase
			end
			// results against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got_l = m_axis_tdata[SW-1:0];
				got_r = m_axis_tdata[2*SW-1:SW];
				if (expected_pairs.size() == 0) begin
					report($sformatf("result %0d with no pair outstanding", results_seen));
				end else begin
					want = expected_pairs.pop_front();
					if (got_l !== want.left)
						report($sformatf("result %0d left: got %0d want %0d", results_seen,
							$signed(got_l), $signed(want.left)));
					if (got_r !== want.right)
						report($sformatf("result %0d right: got %0d want %0d", results_seen,
							$signed(got_r), $signed(want.right)));
				end
				results_seen++;
			end
			// accepted sample pairs
			if (s_axis_tvalid && s_axis_tready) begin
				xl         = $signed(s_axis_tdata[SW-1:0]);
				xr         = $signed(s_axis_tdata[2*SW-1:SW]);
				exp_l      = filter_channel(xl, 0);
				exp_r      = filter_channel(xr, 1);
				want.left  = exp_l;
				want.right = exp_r;
				expected_pairs = {expected_pairs, want};
			end
		end
	end

endmodule

### tb/stereo_state_variable_filter_tb.sv
`timescale 1ns / 1ps

module stereo_state_variable_filter_tb;
	import ssvf_pkg::*;

	localparam int SW          = 24;
	localparam int F           = 16;
	localparam int DW          = ((2*SW+7)/8)*8;
	localparam int ONE         = 1 << F;
	localparam int COEF_MAX    = (1 << (F + 1)) - 1;
	localparam int DAMP_MAX    = (1 << (F + 2)) - 1;
	localparam int SMAX        = (1 << (SW - 1)) - 1;
	localparam int SMIN        = -(1 << (SW - 1));
	localparam int PHASES      = 17;
	localparam int PHASE_PAIRS = 100;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 60;
	localparam int STALL_LIMIT = 3000;

	typedef enum int {SIG_NOISE, SIG_EXTREME, SIG_QUIET, SIG_SQUARE} signal_kind_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [DW-1:0]              s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [DW-1:0]              m_axis_tdata;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [F+1:0]               cfg_data;

	int errors, pending;
	bit source_steady = 1'b0;
	bit sink_steady = 1'b0;
	int pairs_sent = 0;
	int settings_used = 0;

	stereo_state_variable_filter #(.SAMPLE_WIDTH(SW), .COEF_FRAC_BITS(F)) dut (.*);

	stereo_svf_checker #(.SAMPLE_WIDTH(SW), .COEF_FRAC_BITS(F)) checker_i (.*);

	always #2 clk = ~clk;

	// coefficients of a filter with tangent g and damping kr
	function automatic void design_coefs(input real g, input real kr,
			output int a1, output int a2, output int a3);
		real d;
		d  = 1.0 / (1.0 + g * (g + kr));
		a1 = int'(d * ONE);
		a2 = int'(g * d * ONE);
		a3 = int'(g * g * d * ONE);
	endfunction

	// value in the low w bits, random junk above
	function automatic logic [F+1:0] with_junk(input int v, input int w);
		logic [F+1:0] junk, mask;
		junk = (F+2)'($urandom);
		mask = (F+2)'((1 << w) - 1);
		return (junk & ~mask) | ((F+2)'(v) & mask);
	endfunction

	function automatic logic [SW-1:0] make_sample(input signal_kind_t kind, input int n);
		case (kind)
			SIG_EXTREME:
				case ($urandom_range(0, 4))
					0:       return SW'(SMAX);
					1:       return SW'(SMIN);
					2:       return '0;
					3:       return '1;
					default: return SW'(1);
				endcase
			SIG_QUIET:  return SW'(int'($urandom_range(0, 4000)) - 2000);
			SIG_SQUARE: return SW'((n & 8) ? SMAX - int'($urandom_range(0, 255))
				: SMIN + int'($urandom_range(0, 255)));
			default:    return SW'($urandom);
		endcase
	endfunction

	// all tasks start and end on a falling edge
	task automatic send_pair(input logic [SW-1:0] left, input logic [SW-1:0] right);
		int gap;
		gap = source_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {right, left};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [F+1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
	endtask

	// full register set, written once the filter has gone idle
	task automatic apply_setting(input int a1, input int a2, input int a3, input int k,
			input int mode);
		drain();
		write_reg(REG_COEF_A1, with_junk(a1, F + 1));
		write_reg(REG_COEF_A2, with_junk(a2, F + 1));
		write_reg(REG_COEF_A3, with_junk(a3, F + 1));
		write_reg(REG_DAMPING, with_junk(k, F + 2));
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_FILTER_MODE + 1,
				(1 << CFG_INDEX_WIDTH) - 1)), (F+2)'($urandom));
		write_reg(REG_FILTER_MODE, with_junk(mode, MODE_WIDTH));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// result side: random stalls, one long hold to back the filter up
	initial begin : result_sink
		int stall, taken;
		taken = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 15);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			taken++;
			@(negedge clk);
		end
	end

	// ends the run when no channel moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int           p, i, m, a1, a2, a3, k;
		real          g, kr;
		signal_kind_t kind;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults, then writes to the unused indexes must change nothing
		send_pair(SW'(SMAX), SW'(SMIN));
		drain();
		for (i = REG_FILTER_MODE + 1; i < (1 << CFG_INDEX_WIDTH); i++)
			write_reg(CFG_INDEX_WIDTH'(i), (F+2)'($urandom));
		cfg_valid <= 1'b0;
		send_pair(SW'(SMIN), SW'(SMAX));

		// field extremes through every mode code, spare codes included
		design_coefs(0.6, 0.7, a1, a2, a3);
		for (m = 0; m < (1 << MODE_WIDTH); m++) begin
			apply_setting(a1, a2, a3, int'(0.7 * ONE), m);
			send_pair(SW'(SMAX), SW'(SMIN));
			send_pair(SW'(SMIN), SW'(SMAX));
			send_pair('0, '1);
		end

		// random phases: saturating and empty sets first, then mostly real filters
		for (p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				a1 = COEF_MAX; a2 = COEF_MAX; a3 = COEF_MAX; k = DAMP_MAX;
			end else if (p == 1) begin
				a1 = 0; a2 = 0; a3 = 0; k = 0;
			end else if ($urandom_range(0, 5) == 0) begin
				a1 = $urandom_range(0, COEF_MAX);
				a2 = $urandom_range(0, COEF_MAX);
				a3 = $urandom_range(0, COEF_MAX);
				k  = $urandom_range(0, DAMP_MAX);
			end else begin
				g = 0.005 + $urandom_range(0, 3000) / 1000.0;
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(2 * ONE, DAMP_MAX)
					: $urandom_range(ONE / 50, 2 * ONE);
				kr = k / real'(ONE);
				design_coefs(g, kr, a1, a2, a3);
			end
			m             = (p < (1 << MODE_WIDTH)) ? p : $urandom_range(0, (1 << MODE_WIDTH) - 1);
			kind          = signal_kind_t'($urandom_range(SIG_NOISE, SIG_SQUARE));
			source_steady = ($urandom_range(0, 3) == 0);
			sink_steady   = ($urandom_range(0, 3) == 0);
			apply_setting(a1, a2, a3, k, m);
			for (i = 0; i < PHASE_PAIRS; i++)
				send_pair(make_sample(kind, i), make_sample(kind, i));
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d stereo pairs over %0d register settings, all mode codes,",
			pairs_sent, settings_used);
		$display("saturating and zero coefficient sets and a %0d-cycle result hold",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
